// File: hdl/hrp_pkg.sv
// Shared types and codes for the hex record parser.
package hrp_pkg;

   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] TYPE_DATA  = 8'h00;
   localparam logic [7:0] TYPE_EOF   = 8'h01;
   localparam logic [7:0] TYPE_UNIMPL_LAST = 8'h05;

   localparam logic RESULT_WRITE  = 1'b0;
   localparam logic RESULT_STATUS = 1'b1;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_EOF       = 3'd1;
   localparam logic [2:0] STATUS_BAD_START = 3'd2;
   localparam logic [2:0] STATUS_UNIMPL    = 3'd3;
   localparam logic [2:0] STATUS_UNKNOWN   = 3'd4;
   localparam logic [2:0] STATUS_BAD_DIGIT = 3'd5;
   localparam logic [2:0] STATUS_SHORT     = 3'd6;

   typedef struct packed {
      logic [7:0] char_code;
      logic       line_last;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [15:0] write_address;
      logic [7:0]  write_data;
      logic [2:0]  record_status;
      logic [7:0]  record_kind;
      logic        checksum_match;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

endpackage

// File: hdl/hex_record_parser.sv
// Top level of the hex record parser.
// Takes one ASCII character of a hex record line per beat and gives at most one result
// beat per character: a memory write for each data byte of a type 0 record, and a status
// beat on the character flagged as line end. One character is taken every cycle while the
// two-entry result buffer has room; the input stalls only while a character waits in the
// input register and the buffer is full. A result beat goes through the input register, then
// is decoded into the result buffer, which drives rsp; a full buffer can hold it in between.
module hex_record_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hrp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hrp_pkg::rsp_type rsp_data
);

   logic                in_valid_ff, in_valid_in;
   hrp_pkg::req_type    in_data_ff;
   logic                req_accept;
   logic                fire;
   logic                full;
   hrp_pkg::result_type result;

   assign fire       = in_valid_ff && !full;
   assign req_stall  = in_valid_ff && full;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
   end

   hrp_step u_step (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_data_ff),
      .result (result)
   );

   hrp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (fire && result.valid),
      .push_data (result.data),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hdl/hrp_step.sv
// Record parse state and the per-character decode step.
module hrp_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  hrp_pkg::req_type    item,
   output hrp_pkg::result_type result
);

   typedef enum logic [2:0] {
      PH_START,
      PH_COUNT,
      PH_ADDR,
      PH_TYPE,
      PH_DATA,
      PH_SUM,
      PH_DONE,
      PH_SKIP
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  nib_idx_ff, nib_idx_in;
   logic [7:0]  byte_count_ff, byte_count_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [15:0] load_addr_ff, load_addr_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  sum_ff, sum_in;
   logic [15:0] acc_ff, acc_in;
   logic [2:0]  err_ff, err_in;

   logic        nib_ok;
   logic [3:0]  nib;
   logic        field_end;
   logic [7:0]  byte_val;
   logic        wr;
   logic [15:0] wr_addr;
   logic [7:0]  wr_data;
   logic [2:0]  status;
   logic        match;

   always_comb begin
      nib_ok = 1'b1;
      nib    = item.char_code[3:0];
      case (item.char_code) inside
         [8'h30:8'h39]: nib = item.char_code[3:0];
         [8'h41:8'h46], [8'h61:8'h66]: nib = 4'(item.char_code[3:0] + 4'd9);
         default: nib_ok = 1'b0;
      endcase
   end

   always_comb begin
      phase_in      = phase_ff;
      nib_idx_in    = nib_idx_ff;
      byte_count_in = byte_count_ff;
      bytes_left_in = bytes_left_ff;
      load_addr_in  = load_addr_ff;
      type_in       = type_ff;
      sum_in        = sum_ff;
      acc_in        = acc_ff;
      err_in        = err_ff;
      wr            = 1'b0;
      wr_addr       = load_addr_ff;
      wr_data       = '0;
      field_end     = 1'b0;
      byte_val      = '0;
      status        = hrp_pkg::STATUS_OK;
      match         = 1'b0;

      if (phase_ff == PH_START) begin
         nib_idx_in    = '0;
         byte_count_in = '0;
         bytes_left_in = '0;
         load_addr_in  = '0;
         type_in       = '0;
         sum_in        = '0;
         acc_in        = '0;
         err_in        = hrp_pkg::STATUS_OK;
         if (item.char_code == hrp_pkg::CHAR_COLON) begin
            phase_in = PH_COUNT;
         end else begin
            err_in   = hrp_pkg::STATUS_BAD_START;
            phase_in = PH_SKIP;
         end
      end else if (phase_ff inside {PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_SUM}) begin
         if (!nib_ok) begin
            err_in   = hrp_pkg::STATUS_BAD_DIGIT;
            phase_in = PH_SKIP;
         end else begin
            acc_in     = {acc_ff[11:0], nib};
            byte_val   = acc_in[7:0];
            nib_idx_in = nib_idx_ff + 2'd1;
            field_end  = (phase_ff == PH_ADDR) ? (nib_idx_ff == 2'd3) : (nib_idx_ff == 2'd1);
            if (field_end) begin
               nib_idx_in = '0;
               case (phase_ff)
                  PH_COUNT: begin
                     byte_count_in = byte_val;
                     bytes_left_in = byte_val;
                     sum_in        = sum_ff + byte_val;
                     phase_in      = PH_ADDR;
                  end
                  PH_ADDR: begin
                     load_addr_in = acc_in;
                     sum_in       = sum_ff + acc_in[15:8] + byte_val;
                     phase_in     = PH_TYPE;
                  end
                  PH_TYPE: begin
                     type_in  = byte_val;
                     sum_in   = sum_ff + byte_val;
                     phase_in = (byte_count_ff != '0) ? PH_DATA : PH_SUM;
                  end
                  PH_DATA: begin
                     sum_in = sum_ff + byte_val;
                     if (type_ff == hrp_pkg::TYPE_DATA) begin
                        wr           = 1'b1;
                        wr_data      = byte_val;
                        load_addr_in = load_addr_ff + 16'd1;
                     end
                     bytes_left_in = bytes_left_ff - 8'd1;
                     if (bytes_left_in == '0) begin
                        phase_in = PH_SUM;
                     end
                  end
                  default: phase_in = PH_DONE;
               endcase
            end
         end
      end

      if (err_in != hrp_pkg::STATUS_OK) begin
         status = err_in;
      end else if (phase_in != PH_DONE) begin
         status = hrp_pkg::STATUS_SHORT;
      end else if (type_in == hrp_pkg::TYPE_DATA) begin
         status = hrp_pkg::STATUS_OK;
      end else if (type_in == hrp_pkg::TYPE_EOF) begin
         status = hrp_pkg::STATUS_EOF;
      end else if (type_in <= hrp_pkg::TYPE_UNIMPL_LAST) begin
         status = hrp_pkg::STATUS_UNIMPL;
      end else begin
         status = hrp_pkg::STATUS_UNKNOWN;
      end
      match = (phase_in == PH_DONE) && (8'(sum_in + acc_in[7:0]) == 8'd0);

      result.valid               = item.line_last || wr;
      result.data.record_kind    = type_in;
      if (item.line_last) begin
         result.data.result_kind    = hrp_pkg::RESULT_STATUS;
         result.data.write_address  = '0;
         result.data.write_data     = '0;
         result.data.record_status  = status;
         result.data.checksum_match = match;
         phase_in   = PH_START;
         nib_idx_in = '0;
         err_in     = hrp_pkg::STATUS_OK;
      end else begin
         result.data.result_kind    = hrp_pkg::RESULT_WRITE;
         result.data.write_address  = wr_addr;
         result.data.write_data     = wr_data;
         result.data.record_status  = hrp_pkg::STATUS_OK;
         result.data.checksum_match = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         nib_idx_ff    <= '0;
         byte_count_ff <= '0;
         bytes_left_ff <= '0;
         load_addr_ff  <= '0;
         type_ff       <= '0;
         sum_ff        <= '0;
         acc_ff        <= '0;
         err_ff        <= hrp_pkg::STATUS_OK;
      end else if (fire) begin
         phase_ff      <= phase_in;
         nib_idx_ff    <= nib_idx_in;
         byte_count_ff <= byte_count_in;
         bytes_left_ff <= bytes_left_in;
         load_addr_ff  <= load_addr_in;
         type_ff       <= type_in;
         sum_ff        <= sum_in;
         acc_ff        <= acc_in;
         err_ff        <= err_in;
      end
   end

endmodule

// File: hdl/hrp_out_buf.sv
// Two-entry result buffer that drives the response channel.
module hrp_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hrp_pkg::rsp_type push_data,
   output logic             full,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hrp_pkg::rsp_type rsp_data
);

   hrp_pkg::rsp_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: tb/hex_record_parser_tb.sv
// Self-checking testbench for the hex record parser: directed lines, then random records.
module hex_record_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_CYCLES = 20;
   localparam int REPORT_MAX = 10;

   typedef enum logic [2:0] {
      WAIT_COLON, GET_COUNT, GET_ADDR, GET_TYPE, GET_DATA, GET_SUM, LINE_DONE, SKIP_LINE
   } parse_phase_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   hrp_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   hrp_pkg::rsp_type rsp_data;

   hex_record_parser DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // parser shadow state
   parse_phase_type phase = WAIT_COLON;
   logic [1:0]   nib_idx = '0;
   logic [7:0]   rec_count = '0;
   logic [7:0]   rec_left = '0;
   logic [15:0]  rec_addr = '0;
   logic [7:0]   rec_type = '0;
   logic [7:0]   rec_sum = '0;
   logic [15:0]  digit_acc = '0;
   logic [2:0]   line_error = hrp_pkg::STATUS_OK;

   hrp_pkg::rsp_type pending_results[$];
   logic [7:0]       line_chars[$];

   bit idle_on = 1'b1;
   int errors = 0;
   int mismatches = 0;
   int chars_sent = 0;
   int lines_sent = 0;
   int writes_seen = 0;
   int status_seen = 0;
   int cycles = 0;
   int stall_left = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int hex_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      return -1;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 10) return 8'("0") + 8'(n);
      if ($urandom_range(0, 1) == 1) return 8'("a") + 8'(n) - 8'd10;
      return 8'("A") + 8'(n) - 8'd10;
   endfunction

   function automatic logic [7:0] non_hex_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      while (hex_value(c) >= 0) c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   task automatic parse_char(input logic [7:0] c, input logic last);
      int         nib;
      int         need;
      int         idx;
      logic [7:0] b;
      logic       wr;
      logic [15:0] wr_addr;
      logic [7:0] wr_data;
      hrp_pkg::rsp_type r;
      wr = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      r = '0;
      if (phase == WAIT_COLON) begin
         nib_idx = '0;
         rec_count = '0;
         rec_left = '0;
         rec_addr = '0;
         rec_type = '0;
         rec_sum = '0;
         digit_acc = '0;
         line_error = hrp_pkg::STATUS_OK;
         if (c == hrp_pkg::CHAR_COLON) begin
            phase = GET_COUNT;
         end else begin
            line_error = hrp_pkg::STATUS_BAD_START;
            phase = SKIP_LINE;
         end
      end else if (phase inside {GET_COUNT, GET_ADDR, GET_TYPE, GET_DATA, GET_SUM}) begin
         nib = hex_value(c);
         if (nib < 0) begin
            line_error = hrp_pkg::STATUS_BAD_DIGIT;
            phase = SKIP_LINE;
         end else begin
            need = (phase == GET_ADDR) ? 4 : 2;
            idx = int'(nib_idx) + 1;
            digit_acc = {digit_acc[11:0], 4'(nib)};
            if (idx >= need) begin
               b = digit_acc[7:0];
               idx = 0;
               case (phase)
                  GET_COUNT: begin
                     rec_count = b;
                     rec_left = b;
                     rec_sum = rec_sum + b;
                     phase = GET_ADDR;
                  end
                  GET_ADDR: begin
                     rec_addr = digit_acc;
                     rec_sum = rec_sum + digit_acc[15:8] + b;
                     phase = GET_TYPE;
                  end
                  GET_TYPE: begin
                     rec_type = b;
                     rec_sum = rec_sum + b;
                     phase = (rec_count != 0) ? GET_DATA : GET_SUM;
                  end
                  GET_DATA: begin
                     rec_sum = rec_sum + b;
                     if (rec_type == hrp_pkg::TYPE_DATA) begin
                        wr = 1'b1;
                        wr_addr = rec_addr;
                        wr_data = b;
                        rec_addr = rec_addr + 16'd1;
                     end
                     rec_left = rec_left - 8'd1;
                     if (rec_left == 0) phase = GET_SUM;
                  end
                  default: phase = LINE_DONE;
               endcase
            end
            nib_idx = 2'(idx);
         end
      end

      if (last) begin
         r.result_kind = hrp_pkg::RESULT_STATUS;
         if (line_error != hrp_pkg::STATUS_OK) r.record_status = line_error;
         else if (phase != LINE_DONE) r.record_status = hrp_pkg::STATUS_SHORT;
         else if (rec_type == hrp_pkg::TYPE_DATA) r.record_status = hrp_pkg::STATUS_OK;
         else if (rec_type == hrp_pkg::TYPE_EOF) r.record_status = hrp_pkg::STATUS_EOF;
         else if (rec_type <= hrp_pkg::TYPE_UNIMPL_LAST)
            r.record_status = hrp_pkg::STATUS_UNIMPL;
         else r.record_status = hrp_pkg::STATUS_UNKNOWN;
         r.record_kind = rec_type;
         r.checksum_match = (phase == LINE_DONE) && (8'(rec_sum + digit_acc[7:0]) == 8'd0);
         pending_results.push_back(r);
         phase = WAIT_COLON;
         nib_idx = '0;
         line_error = hrp_pkg::STATUS_OK;
      end else if (wr) begin
         r.result_kind = hrp_pkg::RESULT_WRITE;
         r.write_address = wr_addr;
         r.write_data = wr_data;
         r.record_kind = rec_type;
         pending_results.push_back(r);
      end
   endtask

   // Entered at a falling edge; returns at a falling edge.
   task automatic send_char(input logic [7:0] c, input logic last);
      int gap;
      req_data.char_code = c;
      req_data.line_last = last;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      parse_char(c, last);
      chars_sent++;
      @(negedge clock);
      gap = idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_line();
      for (int i = 0; i < line_chars.size(); i++)
         send_char(line_chars[i], i == line_chars.size() - 1);
      line_chars.delete();
      lines_sent++;
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) line_chars.push_back(s[i]);
   endtask

   task automatic put_hex_byte(input logic [7:0] b);
      line_chars.push_back(hex_char(b[7:4]));
      line_chars.push_back(hex_char(b[3:0]));
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic build_random_line();
      int         r;
      int         cnt;
      int         n;
      logic [7:0] rtype;
      logic [15:0] addr;
      logic [7:0] sum;
      logic [7:0] b;
      logic [7:0] c;
      r = $urandom_range(0, 99);
      if (r < 5) begin
         repeat ($urandom_range(1, 6)) line_chars.push_back(8'($urandom_range(0, 255)));
         return;
      end
      r = $urandom_range(0, 99);
      if (r < 85) cnt = $urandom_range(0, 8);
      else if (r < 98) cnt = $urandom_range(9, 32);
      else cnt = $urandom_range(128, 255);
      r = $urandom_range(0, 99);
      if (r < 55) rtype = hrp_pkg::TYPE_DATA;
      else if (r < 65) rtype = hrp_pkg::TYPE_EOF;
      else if (r < 80) rtype = 8'($urandom_range(2, 5));
      else rtype = 8'($urandom_range(6, 255));
      addr = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(16'hfff0, 16'hffff))
                                         : 16'($urandom_range(0, 16'hffff));
      line_chars.push_back(hrp_pkg::CHAR_COLON);
      sum = 8'(cnt) + addr[15:8] + addr[7:0] + rtype;
      put_hex_byte(8'(cnt));
      put_hex_byte(addr[15:8]);
      put_hex_byte(addr[7:0]);
      put_hex_byte(rtype);
      repeat (cnt) begin
         b = 8'($urandom_range(0, 255));
         sum = sum + b;
         put_hex_byte(b);
      end
      put_hex_byte(($urandom_range(0, 4) != 0) ? 8'(-sum) : 8'($urandom_range(0, 255)));
      r = $urandom_range(0, 99);
      if (r < 8) begin
         n = $urandom_range(1, line_chars.size() - 1);
         line_chars = line_chars[0:n-1];
      end else if (r < 16) begin
         line_chars[$urandom_range(1, line_chars.size() - 1)] = non_hex_char();
      end else if (r < 21) begin
         c = 8'($urandom_range(0, 255));
         while (c == hrp_pkg::CHAR_COLON) c = 8'($urandom_range(0, 255));
         line_chars[0] = c;
      end else if (r < 30) begin
         repeat ($urandom_range(1, 3)) line_chars.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_directed_lines();
      line_chars.push_back(8'hff);
      send_line();
      put_text(":");
      send_line();
      put_text(":0g");
      send_line();
      put_text(":00ffff0101");
      send_line();
      put_text(":01FFFF00A5");
      send_line();
   endtask

   task automatic test_random_records(input int n_chars);
      int stop_at;
      stop_at = chars_sent + n_chars;
      while (chars_sent < stop_at) begin
         build_random_line();
         send_line();
      end
   endtask

   task automatic test_drain_pause();
      test_random_records(60);
      wait_drained();
      test_random_records(60);
   endtask

   task automatic test_back_to_back();
      idle_on = 1'b0;
      test_random_records(150);
      idle_on = 1'b1;
   endtask

   always @(negedge clock) begin
      if (!idle_on) begin
         rsp_stall = 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else begin
         rsp_stall = ($urandom_range(0, 2) == 0);
         stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin : check_results
      hrp_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_data.result_kind == hrp_pkg::RESULT_WRITE) writes_seen++;
         else status_seen++;
         if (pending_results.size() == 0) begin
            errors++;
            if (++mismatches <= REPORT_MAX)
               $display("unexpected result beat: kind %0d addr %h data %h status %0d",
                        rsp_data.result_kind, rsp_data.write_address, rsp_data.write_data,
                        rsp_data.record_status);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.result_kind != want.result_kind ||
                rsp_data.write_address != want.write_address ||
                rsp_data.write_data != want.write_data ||
                rsp_data.record_status != want.record_status ||
                rsp_data.record_kind != want.record_kind ||
                rsp_data.checksum_match != want.checksum_match) begin
               errors++;
               if (++mismatches <= REPORT_MAX) begin
                  $display("mismatch: want kind %0d addr %h data %h st %0d type %h ok %0d",
                           want.result_kind, want.write_address, want.write_data,
                           want.record_status, want.record_kind, want.checksum_match);
                  $display("          got  kind %0d addr %h data %h st %0d type %h ok %0d",
                           rsp_data.result_kind, rsp_data.write_address, rsp_data.write_data,
                           rsp_data.record_status, rsp_data.record_kind,
                           rsp_data.checksum_match);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("hex_record_parser_tb NOT OK");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_lines();
      test_random_records(500);
      test_drain_pause();
      test_back_to_back();
      test_random_records(250);
      req_valid = 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) errors++;
      $display("sent %0d lines in %0d characters, with idle and stall gaps and a no-gap stretch",
               lines_sent, chars_sent);
      $display("checked %0d memory writes and %0d line status beats", writes_seen, status_seen);
      if (errors == 0) begin
         $display("hex_record_parser_tb OK");
      end else begin
         $display("%0d failures", errors);
         $display("hex_record_parser_tb NOT OK");
      end
      $finish;
   end

endmodule
